@@ hw/rtl/shp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types, constants and the half-step coil table for the stepper
// half-step positioner.
// ----------------------------------------------------------------------------
package shp_pkg;

   // Motor geometry and field widths
   localparam int unsigned STEPS_PER_REV = 4096;
   localparam int unsigned POS_WIDTH     = 13;
   localparam int unsigned PCT_WIDTH     = 7;
   localparam int unsigned PCT_MAX       = 100;
   localparam int unsigned PHASE_WIDTH   = 3;
   localparam int unsigned COIL_WIDTH    = 4;

   // floor(pct * STEPS_PER_REV / 100) as a multiply by a rounded-up
   // reciprocal; 16 fraction bits keep the error below 1/100 for pct <= 100.
   localparam int unsigned SCALE_SHIFT = 16;
   localparam longint unsigned SCALE_MULT =
      (longint'(STEPS_PER_REV) * (longint'(1) << SCALE_SHIFT) + PCT_MAX - 1) / PCT_MAX;
   localparam int unsigned SCALE_WIDTH = $clog2(SCALE_MULT + 1);
   localparam int unsigned PROD_WIDTH  = PCT_WIDTH + SCALE_WIDTH;

   typedef enum logic {
      CMD_SET_TARGET = 1'b0,
      CMD_TICK       = 1'b1
   } command_type;

   typedef struct packed {
      command_type        command;
      logic signed [7:0]  percent;
   } req_payload_type;

   typedef struct packed {
      logic [COIL_WIDTH-1:0] coil_pattern;
      logic                  moving;
      logic [POS_WIDTH-1:0]  position;
   } rsp_payload_type;

   // Request after the input register: command and scaled target
   typedef struct packed {
      command_type          command;
      logic [POS_WIDTH-1:0] target;
   } intake_item_type;

   // Half-step coil sequence, IN4..IN1
   function automatic logic [COIL_WIDTH-1:0] half_step_pattern(
      input logic [PHASE_WIDTH-1:0] idx);
      logic [COIL_WIDTH-1:0] pat;
      unique case (idx)
         3'd0:    pat = 4'h8;
         3'd1:    pat = 4'hC;
         3'd2:    pat = 4'h4;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h2;
         3'd5:    pat = 4'h3;
         3'd6:    pat = 4'h1;
         3'd7:    pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

@@ hw/rtl/shp_intake.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_intake
// Input register. Clamps the percent to 0..100 and scales it to a target
// step count on the way in.
// ----------------------------------------------------------------------------
module shp_intake (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  shp_pkg::req_payload_type req_payload,
   input  logic                     core_ready,
   output logic                     item_valid,
   output shp_pkg::intake_item_type item
);

   logic                          item_valid_ff;
   shp_pkg::intake_item_type      item_ff;
   logic                          load_en;
   logic [shp_pkg::PCT_WIDTH-1:0] pct_clamped;
   logic [shp_pkg::PROD_WIDTH-1:0] scaled;
   shp_pkg::intake_item_type      item_in;

   // Register frees up when empty or when the core takes its request
   assign load_en   = !item_valid_ff || core_ready;
   assign req_stall = !load_en;

   // Clamp to 0..100
   always_comb begin
      priority if (req_payload.percent[7]) begin
         pct_clamped = '0;
      end else if (req_payload.percent > 8'sd100) begin
         pct_clamped = shp_pkg::PCT_WIDTH'(shp_pkg::PCT_MAX);
      end else begin
         pct_clamped = req_payload.percent[shp_pkg::PCT_WIDTH-1:0];
      end
   end

   // Scale by STEPS_PER_REV / 100
   assign scaled = shp_pkg::PROD_WIDTH'(pct_clamped)
                 * shp_pkg::PROD_WIDTH'(shp_pkg::SCALE_MULT);

   always_comb begin
      item_in.command = req_payload.command;
      item_in.target  = scaled[shp_pkg::SCALE_SHIFT +: shp_pkg::POS_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (load_en) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

@@ hw/rtl/shp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_core
// Position, target, phase and coil state, with the result register.
// Moves one half step toward the target on each tick.
// ----------------------------------------------------------------------------
module shp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  shp_pkg::intake_item_type item,
   output logic                     core_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output shp_pkg::rsp_payload_type rsp_payload
);

   logic [shp_pkg::POS_WIDTH-1:0]   current_ff, current_in;
   logic [shp_pkg::POS_WIDTH-1:0]   target_ff, target_in;
   logic [shp_pkg::PHASE_WIDTH-1:0] phase_ff, phase_in, phase_back;
   logic [shp_pkg::COIL_WIDTH-1:0]  pattern_ff, pattern_in;
   logic                            rsp_valid_ff;
   shp_pkg::rsp_payload_type        rsp_payload_ff, rsp_payload_in;
   logic                            consume;

   // Result slot is free when empty or being drained this cycle
   assign core_ready = !rsp_valid_ff || !rsp_stall;
   assign consume    = item_valid && core_ready;

   assign phase_back = phase_ff - 1'b1;

   // Next state
   always_comb begin
      current_in = current_ff;
      target_in  = target_ff;
      phase_in   = phase_ff;
      pattern_in = pattern_ff;
      unique case (item.command)
         shp_pkg::CMD_SET_TARGET: begin
            target_in = item.target;
         end
         shp_pkg::CMD_TICK: begin
            priority if (current_ff < target_ff) begin
               // forward: drive current phase, then advance
               pattern_in = shp_pkg::half_step_pattern(phase_ff);
               phase_in   = phase_ff + 1'b1;
               current_in = current_ff + 1'b1;
            end else if (current_ff > target_ff) begin
               // reverse: back the phase up first, then drive it
               pattern_in = shp_pkg::half_step_pattern(phase_back);
               phase_in   = phase_back;
               current_in = current_ff - 1'b1;
            end else begin
               pattern_in = pattern_ff;
            end
         end
         default: begin
            target_in = target_ff;
         end
      endcase
   end

   always_comb begin
      rsp_payload_in.coil_pattern = pattern_in;
      rsp_payload_in.moving       = (current_in != target_in);
      rsp_payload_in.position     = current_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         target_ff    <= '0;
         phase_ff     <= '0;
         pattern_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (core_ready) begin
            rsp_valid_ff <= item_valid;
         end
         if (consume) begin
            current_ff <= current_in;
            target_ff  <= target_in;
            phase_ff   <= phase_in;
            pattern_ff <= pattern_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hw/rtl/stepper_half_step_positioner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_positioner_unit
// Half-step positioner for a four-coil stepper. Every request returns the
// coil pattern, a moving flag and the position. Requests are taken one per
// cycle while req_stall is low; a response passes the input register, then
// the result register. The rate is set by the position and phase update in
// the core, which is done as each request is consumed, so that each
// request sees the state left by the one before it.
// ----------------------------------------------------------------------------
module stepper_half_step_positioner_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  shp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output shp_pkg::rsp_payload_type rsp_payload
);

   logic                     item_valid;
   shp_pkg::intake_item_type item;
   logic                     core_ready;

   // Input register with target scaling
   shp_intake u_intake (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .core_ready  (core_ready),
      .item_valid  (item_valid),
      .item        (item)
   );

   // State update and result register
   shp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .core_ready  (core_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/shp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks for the stepper half-step positioner, bound to the
// top level.
// ----------------------------------------------------------------------------
module shp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input shp_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input shp_pkg::rsp_payload_type rsp_payload
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Every accepted request is followed by a valid response
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   // Position never passes one revolution
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.position <= shp_pkg::POS_WIDTH'(shp_pkg::STEPS_PER_REV))
      else $error("position out of range");

   // Coils carry off or a half-step pattern
   a_coil_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.coil_pattern == 4'h0 || rsp_payload.coil_pattern == 4'h8
         || rsp_payload.coil_pattern == 4'hC || rsp_payload.coil_pattern == 4'h4
         || rsp_payload.coil_pattern == 4'h6 || rsp_payload.coil_pattern == 4'h2
         || rsp_payload.coil_pattern == 4'h3 || rsp_payload.coil_pattern == 4'h1
         || rsp_payload.coil_pattern == 4'h9))
      else $error("illegal coil pattern");

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stepper_half_step_positioner_unit shp_checker u_shp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper half-step positioner. A queue of
// requests (a short directed list, then random set/tick sequences) feeds a
// clocked driver. A behavioral motor model predicts each response. A clocked
// monitor compares every response field by field. Both sides idle in random
// bursts, and one long receiver hold-off backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ITEM_TARGET  = 1900;  // approximate request count
   localparam int TAIL_ITEMS   = 250;   // final stretch runs with no idling
   localparam int HOLD_AT      = 400;   // accepted requests before the hold-off
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 10;

   // Half-step coil sequence, IN4..IN1
   localparam logic [shp_pkg::COIL_WIDTH-1:0] COIL_SEQ [8] =
      '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   shp_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall;
   shp_pkg::rsp_payload_type rsp_payload;

   logic            rsp_busy    = 1'b0;  // short random stall bursts
   logic            hold_off    = 1'b0;  // one long hold-off

   shp_pkg::req_payload_type request_q[$];
   shp_pkg::rsp_payload_type predicted_rsp_q[$];

   // Motor model state
   logic [shp_pkg::POS_WIDTH-1:0]   model_pos;
   logic [shp_pkg::POS_WIDTH-1:0]   model_target;
   logic [shp_pkg::PHASE_WIDTH-1:0] model_phase;
   logic [shp_pkg::COIL_WIDTH-1:0]  model_coils;

   int item_total;
   int accepted_count;
   int checked_count;
   int error_count;
   int send_gap;
   int stall_left;
   int hold_left;
   bit hold_done;
   shp_pkg::rsp_payload_type want;

   always #4 clock = ~clock;

   assign rsp_stall = rsp_busy | hold_off;

   stepper_half_step_positioner_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Apply one request to the motor model and return the response it gives
   function automatic shp_pkg::rsp_payload_type advance_motor(
      input shp_pkg::req_payload_type rq);
      int                       pct;
      int unsigned              scaled;
      shp_pkg::rsp_payload_type r;
      if (rq.command == shp_pkg::CMD_SET_TARGET) begin
         pct = int'(rq.percent);
         if (pct < 0) pct = 0;
         if (pct > shp_pkg::PCT_MAX) pct = shp_pkg::PCT_MAX;
         scaled = pct * shp_pkg::STEPS_PER_REV / shp_pkg::PCT_MAX;
         model_target = scaled[shp_pkg::POS_WIDTH-1:0];
      end else if (model_pos < model_target) begin
         // forward: drive current phase, then advance
         model_coils = COIL_SEQ[model_phase];
         model_phase = model_phase + 1'b1;
         model_pos   = model_pos + 1'b1;
      end else if (model_pos > model_target) begin
         // reverse: back the phase up first, then drive it
         model_phase = model_phase - 1'b1;
         model_coils = COIL_SEQ[model_phase];
         model_pos   = model_pos - 1'b1;
      end
      r.coil_pattern = model_coils;
      r.moving       = (model_pos != model_target);
      r.position     = model_pos;
      return r;
   endfunction

   task automatic queue_request(input shp_pkg::command_type cmd, input logic [7:0] pct);
      shp_pkg::req_payload_type rq;
      rq.command = cmd;
      rq.percent = pct;
      request_q.push_back(rq);
   endtask

   // Driver: present queued requests, predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp_q.push_back(advance_motor(req_payload));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 15) - 1;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_payload <= request_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check responses in order, and stall the response side in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_busy <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (predicted_rsp_q.size() == 0) begin
               $error("unexpected response: coil_pattern %h moving %0d position %0d",
                      rsp_payload.coil_pattern, rsp_payload.moving, rsp_payload.position);
               error_count++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_payload.coil_pattern !== want.coil_pattern) begin
                  $error("coil_pattern: expected %h, got %h",
                         want.coil_pattern, rsp_payload.coil_pattern);
                  error_count++;
               end
               if (rsp_payload.moving !== want.moving) begin
                  $error("moving: expected %0d, got %0d", want.moving, rsp_payload.moving);
                  error_count++;
               end
               if (rsp_payload.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         want.position, rsp_payload.position);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_busy <= 1'b1;
         end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_busy <= 1'b1;
         end else begin
            rsp_busy <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, once, while the driver keeps offering requests
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         hold_off <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   // Stimulus and end of run
   initial begin
      int          roll;
      int          run_len;
      logic [7:0]  pct;
      model_pos      = '0;
      model_target   = '0;
      model_phase    = '0;
      model_coils    = '0;
      accepted_count = 0;
      checked_count  = 0;
      error_count    = 0;

      // tick before any step: coils still off
      queue_request(shp_pkg::CMD_TICK, 8'h00);
      // clamping at both ends
      queue_request(shp_pkg::CMD_SET_TARGET, 8'h80);
      queue_request(shp_pkg::CMD_SET_TARGET, 8'hFF);
      queue_request(shp_pkg::CMD_SET_TARGET, 8'd101);
      queue_request(shp_pkg::CMD_SET_TARGET, 8'h7F);
      // forward walk across the phase wrap
      repeat (9) queue_request(shp_pkg::CMD_TICK, 8'h7F);
      // reverse walk back through the wrap, then ticks at target
      queue_request(shp_pkg::CMD_SET_TARGET, 8'h00);
      repeat (10) queue_request(shp_pkg::CMD_TICK, 8'h80);

      // random set/tick sequences, mostly short moves
      while (request_q.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) pct = 8'($urandom_range(0, 4));
         else if (roll < 85) pct = 8'($urandom_range(0, 100));
         else pct = 8'($urandom_range(0, 255));
         queue_request(shp_pkg::CMD_SET_TARGET, pct);
         run_len = $urandom_range(1, 90);
         repeat (run_len) queue_request(shp_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
      end
      item_total = request_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (checked_count < item_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", predicted_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("** stepper_half_step_positioner_unit: PASSED **");
      end else begin
         $display("** stepper_half_step_positioner_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("** stepper_half_step_positioner_unit: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/shp_pkg.sv
hw/rtl/shp_intake.sv
hw/rtl/shp_core.sv
hw/rtl/stepper_half_step_positioner_unit.sv
hw/rtl/shp_checker.sv
bench/testbench.sv
